>>> design/cfq_pkg.sv
// Shared types, constants and codes of the circular FIFO queue.
package cfq_pkg;

  // Built depth of the queue and derived widths.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;

  // Output tdata width: read value, empty, full and occupancy, padded to bytes.
  localparam int unsigned M_RAW_W  = WORD_W + 2 + OCC_W;
  localparam int unsigned M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

  // Capacity register value after reset.
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

  // Operation codes carried on the input word.
  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } cfq_op_e;

  // Status codes carried on the output word.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RSVD  = 2'd3
  } cfq_status_e;

  // Control broadcast from the queue controller to every cell.
  typedef struct packed {
    logic              clear;
    logic              shift;
    logic              load;
    logic [WORD_W-1:0] push_word;
  } cfq_ctrl_t;

endpackage

>>> design/cfq_cell.sv
// One storage cell of the queue chain: holds one word and its valid bit.
module cfq_cell
  import cfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfq_ctrl_t         ctrl_i,
  input  logic              prev_valid_i,
  input  logic              next_valid_i,
  input  logic [WORD_W-1:0] next_data_i,
  output logic              valid_o,
  output logic [WORD_W-1:0] data_o
);

  logic              valid_q, valid_d;
  logic [WORD_W-1:0] data_q, data_d;
  logic              take_push;

  // The first empty cell behind the occupied prefix takes an enqueued word.
  assign take_push = ctrl_i.load && !valid_q && prev_valid_i;

  // Next state: clear, shift toward the front, or capture the pushed word.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (take_push) begin
      valid_d = 1'b1;
      data_d  = ctrl_i.push_word;
    end
  end

  // Valid bit is control state; the word itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/circular_fifo_queue_top.sv
// Top level of the circular FIFO queue: controller, cell chain and output register.
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one operation per cycle unless the output stalls; the front of the queue
// is always cell 0 of the chain, and every cell moves one word per cycle on a dequeue.
// The output register frees itself when the result is taken in the same cycle.
// Reset empties the queue and sets the capacity in use to the built depth;
// a capacity write also empties the queue.
module circular_fifo_queue_top
  import cfq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Capacity in use.
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // Input words.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WORD_W-1:0]   s_axis_tdata,   // [31:0] push_value
  input  logic [OP_W-1:0]     s_axis_tuser,   // [1:0] opcode
  // Result words.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // [31:0] read_value, [32] empty_flag,
                                              // [33] full_flag, [38:34] occupancy, rest 0
  output logic [ST_W-1:0]     m_axis_tuser    // [1:0] status
);

  logic [CFG_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  live_cap;
  logic              accept;
  cfq_op_e           op;
  logic              is_full, queue_empty;
  logic              do_enq, do_deq, do_read;
  cfq_status_e       status;
  logic [WORD_W-1:0] read_word;
  cfq_ctrl_t         ctrl;

  logic [DEPTH-1:0]  cell_valid;
  logic [WORD_W-1:0] cell_data [DEPTH];

  logic              m_valid_q;
  logic [WORD_W-1:0] rd_q;
  cfq_status_e       st_q;
  logic              empty_q, full_q;
  logic [OCC_W-1:0]  occ_q;

  // Capacity register; out-of-range values are clamped on use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      live_cap = CNT_W'(1);
    end else if (CNT_W'(cap_q) > CNT_W'(DEPTH) || cap_q > CFG_W'(DEPTH)) begin
      live_cap = CNT_W'(DEPTH);
    end else begin
      live_cap = CNT_W'(cap_q);
    end
  end

  // Handshake: take a new word whenever the output register is free or draining.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = cfq_op_e'(s_axis_tuser);

  // Decode the operation against the current occupancy.
  assign is_full     = (count_q >= live_cap);
  assign queue_empty = (count_q == '0);
  assign do_enq      = accept && (op == OP_ENQ) && !is_full;
  assign do_read     = accept && (op inside {OP_DEQ, OP_PEEK}) && !queue_empty;
  assign do_deq      = do_read && (op == OP_DEQ);

  always_comb begin
    status    = ST_OK;
    read_word = '1;
    case (op)
      OP_ENQ: begin
        if (is_full) begin
          status = ST_OVER;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (queue_empty) begin
          status = ST_UNDER;
        end else begin
          read_word = cell_data[0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Occupancy counter.
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = '0;
    end else if (do_enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Broadcast control to the cell chain.
  assign ctrl.clear     = cfg_we_i;
  assign ctrl.shift     = do_deq;
  assign ctrl.load      = do_enq;
  assign ctrl.push_word = s_axis_tdata;

  // Row of cells; cell 0 is the front, each shifts in its neighbor's word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_valid;
    logic              next_valid;
    logic [WORD_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_link
      assign next_valid = cell_valid[i+1];
      assign next_data  = cell_data[i+1];
    end

    cfq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_data_i  (next_data),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i])
    );
  end

  // Output register: valid bit under reset, payload captured on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q    <= read_word;
      st_q    <= status;
      empty_q <= (count_d == '0);
      full_q  <= (count_d == live_cap);
      occ_q   <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = st_q;
  assign m_axis_tdata  = M_DATA_W'({occ_q, full_q, empty_q, rd_q});

  // Occupancy never exceeds the capacity in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= live_cap)
    else $error("occupancy above capacity in use");

  // The cells hold exactly as many words as the counter says.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("cell valid bits disagree with occupancy");

  // The occupied cells form a prefix starting at the front.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("cell chain has a gap");

endmodule

>>> verif/tb_circular_fifo_queue_top.sv
// Self-checking testbench of the circular FIFO queue top level.
module tb_circular_fifo_queue_top;
  import cfq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  // One result word split into its fields.
  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    cfq_status_e       status;
    logic              empty;
    logic              full;
    logic [OCC_W-1:0]  occupancy;
  } fifo_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [WORD_W-1:0]   s_axis_tdata;
  logic [OP_W-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]     m_axis_tuser;

  // Software copy of the queue.
  logic [WORD_W-1:0] slot_words [DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  fill_cnt;
  logic [CFG_W-1:0]  capacity_reg;

  fifo_result_t pending_results [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned err_cnt;
  int unsigned sent_words;
  int unsigned checked_words;
  int unsigned overflow_seen;
  int unsigned underflow_seen;
  int unsigned full_seen;

  circular_fifo_queue_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Effective capacity: zero acts as one, anything above the depth as the depth.
  function automatic int unsigned live_capacity();
    int unsigned c;
    c = capacity_reg;
    if (c < 1) begin
      c = 1;
    end
    if (c > DEPTH) begin
      c = DEPTH;
    end
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p, int unsigned lim);
    return (p + 1 >= lim) ? '0 : PTR_W'(p + 1);
  endfunction

  task automatic clear_queue_model();
    rd_ptr   = '0;
    wr_ptr   = '0;
    fill_cnt = '0;
  endtask

  // Applies one operation to the queue copy and returns the result it yields.
  function automatic fifo_result_t apply_queue_op(cfq_op_e op, logic [WORD_W-1:0] value);
    fifo_result_t r;
    int unsigned  lim;
    lim          = live_capacity();
    r.read_value = '1;
    r.status     = ST_OK;
    case (op)
      OP_ENQ: begin
        if (fill_cnt >= lim) begin
          r.status = ST_OVER;
        end else begin
          slot_words[wr_ptr] = value;
          wr_ptr             = next_slot(wr_ptr, lim);
          fill_cnt           = fill_cnt + 1'b1;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (fill_cnt == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.read_value = slot_words[rd_ptr];
          if (op == OP_DEQ) begin
            rd_ptr   = next_slot(rd_ptr, lim);
            fill_cnt = fill_cnt - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.empty     = (fill_cnt == 0);
    r.full      = (fill_cnt == lim);
    r.occupancy = OCC_W'(fill_cnt);
    return r;
  endfunction

  // Reports a field mismatch; only the first few are printed.
  task automatic note_mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  // Receiver: stalls at random according to the current mix.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Tracks register writes and accepted words, and checks every result word.
  always @(posedge clk_i) begin
    fifo_result_t want;
    fifo_result_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        capacity_reg = cfg_wdata_i;
        clear_queue_model();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_queue_op(cfq_op_e'(s_axis_tuser), s_axis_tdata);
        pending_results.push_back(want);
        sent_words++;
        if (want.status == ST_OVER) overflow_seen++;
        if (want.status == ST_UNDER) underflow_seen++;
        if (want.full) full_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_value = m_axis_tdata[WORD_W-1:0];
        got.empty      = m_axis_tdata[WORD_W];
        got.full       = m_axis_tdata[WORD_W+1];
        got.occupancy  = m_axis_tdata[WORD_W+2 +: OCC_W];
        got.status     = cfq_status_e'(m_axis_tuser);
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result word", '0, got.read_value);
        end else begin
          want = pending_results.pop_front();
          checked_words++;
          if (got.read_value !== want.read_value) begin
            note_mismatch("read_value", want.read_value, got.read_value);
          end
          if (got.status !== want.status) begin
            note_mismatch("status", want.status, got.status);
          end
          if (got.empty !== want.empty) begin
            note_mismatch("empty_flag", want.empty, got.empty);
          end
          if (got.full !== want.full) begin
            note_mismatch("full_flag", want.full, got.full);
          end
          if (got.occupancy !== want.occupancy) begin
            note_mismatch("occupancy", want.occupancy, got.occupancy);
          end
        end
      end
    end
  end

  // Selects one of the four idling mixes.
  task automatic set_idling(int unsigned mix);
    case (mix)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 65; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 65; end
      default: begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  // Sends one word and returns at the edge where it was taken.
  task automatic send_word(cfq_op_e op, logic [WORD_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Operation mix depends on whether the run is filling, draining or mixed.
  function automatic cfq_op_e pick_op(int unsigned mode);
    int unsigned r;
    r = $urandom_range(99);
    case (mode)
      0: return (r < 70) ? OP_ENQ : (r < 82) ? OP_DEQ : (r < 94) ? OP_PEEK : OP_NOP;
      1: return (r < 70) ? OP_DEQ : (r < 80) ? OP_ENQ : (r < 94) ? OP_PEEK : OP_NOP;
      default: return (r < 40) ? OP_ENQ : (r < 75) ? OP_DEQ : (r < 95) ? OP_PEEK : OP_NOP;
    endcase
  endfunction

  // Mostly random words, with the signed extremes now and then.
  function automatic logic [WORD_W-1:0] pick_value();
    if ($urandom_range(7) != 0) begin
      return $urandom();
    end
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  // Every operation at the reset capacity, with errors on the empty queue.
  task automatic test_basic_ops();
    set_idling(0);
    send_word(OP_PEEK, 32'h0);
    send_word(OP_DEQ,  32'h1234_5678);
    send_word(OP_ENQ,  32'h7FFF_FFFF);
    send_word(OP_ENQ,  32'h8000_0000);
    send_word(OP_ENQ,  32'hFFFF_FFFF);
    send_word(OP_ENQ,  32'h0000_0000);
    send_word(OP_PEEK, 32'hDEAD_BEEF);
    send_word(OP_NOP,  32'hA5A5_5A5A);
    repeat (4) send_word(OP_DEQ, 32'h0);
    send_word(OP_DEQ,  32'hFFFF_FFFF);
    wait_drained();
  endtask

  // A zero capacity acts as one; a capacity of two exercises the pointer wrap.
  task automatic test_small_capacity();
    set_idling(3);
    write_capacity(5'd0);
    send_word(OP_ENQ,  32'h0000_0001);
    send_word(OP_ENQ,  32'h0000_0002);
    send_word(OP_PEEK, 32'h0);
    send_word(OP_DEQ,  32'h0);
    send_word(OP_DEQ,  32'h0);
    wait_drained();
    write_capacity(5'd2);
    send_word(OP_ENQ, 32'h1111_1111);
    send_word(OP_ENQ, 32'h2222_2222);
    send_word(OP_ENQ, 32'h3333_3333);
    send_word(OP_DEQ, 32'h0);
    send_word(OP_ENQ, 32'h4444_4444);
    send_word(OP_DEQ, 32'h0);
    send_word(OP_DEQ, 32'h0);
    wait_drained();
  endtask

  // Fill, drain and mixed runs with random content over several capacities.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] caps [8] = '{5'd31, 5'd1, 5'd6, 5'd16, 5'd0, 5'd17, 5'd3, 5'd16};
    int unsigned      mode;
    int unsigned      run_left;
    run_left = 0;
    mode     = 2;
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      write_capacity(caps[ph]);
      for (int n = 0; n < 56; n++) begin
        if (run_left == 0) begin
          mode     = $urandom_range(2);
          run_left = $urandom_range(20, 4);
        end
        run_left--;
        send_word(pick_op(mode), pick_value());
      end
      wait_drained();
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_NOP;
    idle_pct       = 0;
    stall_pct      = 0;
    err_cnt        = 0;
    sent_words     = 0;
    checked_words  = 0;
    overflow_seen  = 0;
    underflow_seen = 0;
    full_seen      = 0;
    capacity_reg   = CAP_RESET;
    clear_queue_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_small_capacity();
    test_random_traffic();

    $display("Sent %0d operations and checked %0d results across capacities 0 to 31.",
             sent_words, checked_words);
    $display("Seen: %0d overflows, %0d underflows, %0d results with the queue full.",
             overflow_seen, underflow_seen, full_seen);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
design/cfq_pkg.sv
design/cfq_cell.sv
design/circular_fifo_queue_top.sv
verif/tb_circular_fifo_queue_top.sv
